>>> design/sfr_pkg.sv
// Shared types, constants and helpers of the stream find-and-replace unit.
package sfr_pkg;

  localparam int unsigned MaxWordBytesDef = 16;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned LenW            = 5;
  localparam int unsigned IdxW4           = 4;
  localparam int unsigned ReplMaxBytes    = 16;
  localparam int unsigned CfgAddrW        = 3;
  localparam int unsigned CfgDataW        = 64;

  localparam logic [CfgAddrW-1:0] CfgPatLo  = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgPatHi  = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgPatLen = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgRepLo  = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgRepHi  = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgRepLen = 3'd5;

  // What a pending burst of results is drawn from.
  typedef enum logic [1:0] {
    BURST_REPL,
    BURST_WIN,
    BURST_MARK
  } sfr_kind_e;

  typedef struct packed {
    sfr_kind_e        kind;
    logic [IdxW4-1:0] idx;
    logic [LenW-1:0]  rem;
    logic             done;
  } sfr_burst_t;

  function automatic logic [ByteW-1:0] pick_byte(input logic [2*CfgDataW-1:0] w,
                                                 input logic [IdxW4-1:0] idx);
    pick_byte = w[{idx, 3'b000} +: ByteW];
  endfunction

endpackage

>>> design/stream_find_and_replace_unit.sv
// A transfer loads its results into the burst register of the sequencer, from which they enter
// the output register one by one, where the receiver can take them.
// Throughput: one input transfer per cycle while each byte causes at most one result and the
// receiver takes every result; a byte that causes more holds the input while the sequencer emits them.
// Bytes wait in the window cells until the pattern length is reached or the string ends.
// Reset clears the window fill, the burst and the output valid flag, and sets the registers to their defaults.
module stream_find_and_replace_unit
  import sfr_pkg::*;
#(
  parameter int unsigned MaxWordBytes = MaxWordBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] text_byte
  input  logic                s_axis_tlast_i,   // end_of_text
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o,   // [7:0] out_byte, [8] run_last, zero above
  output logic [0:0]          m_axis_tuser_o,   // [0] byte_present
  output logic                m_axis_tlast_o    // string_done
);

  localparam int unsigned FillW = $clog2(MaxWordBytes + 1);

  logic [CfgDataW-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [LenW-1:0]     pat_len_q, rep_len_q;
  logic [FillW-1:0]    fill_q, fill_d;

  logic [LenW-1:0]  plen, rlen, fill_cur, fill_new;
  logic             accept, last, full, hit;
  sfr_burst_t       burst_load;
  logic [ByteW-1:0] cell_byte [MaxWordBytes];
  logic [ByteW-1:0] cell_snap [MaxWordBytes];
  logic [ByteW-1:0] cell_pat  [MaxWordBytes];
  logic             cell_match [MaxWordBytes];
  logic             cell_used  [MaxWordBytes];
  logic [ByteW-1:0] out_byte;
  logic             out_run_last;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign last   = s_axis_tlast_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= LenW'(1);
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      rep_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgPatLo:  pat_lo_q  <= cfg_wdata_i;
        CfgPatHi:  pat_hi_q  <= cfg_wdata_i;
        CfgPatLen: pat_len_q <= cfg_wdata_i[LenW-1:0];
        CfgRepLo:  rep_lo_q  <= cfg_wdata_i;
        CfgRepHi:  rep_hi_q  <= cfg_wdata_i;
        CfgRepLen: rep_len_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Zero pattern length acts as one; pattern length clips at the window depth, replacement at ReplMaxBytes.
  always_comb begin
    if (pat_len_q == '0) begin
      plen = LenW'(1);
    end else if (pat_len_q > LenW'(MaxWordBytes)) begin
      plen = LenW'(MaxWordBytes);
    end else begin
      plen = pat_len_q;
    end
    rlen     = (rep_len_q > LenW'(ReplMaxBytes)) ? LenW'(ReplMaxBytes) : rep_len_q;
    fill_cur = (LenW'(fill_q) >= plen) ? (plen - LenW'(1)) : LenW'(fill_q);
    fill_new = fill_cur + LenW'(1);
    full     = (fill_new == plen);
  end

  // The newest byte sits in cell 0, so cell k compares with pattern byte plen-1-k.
  for (genvar k = 0; k < MaxWordBytes; k++) begin : g_cell
    assign cell_used[k] = (LenW'(k) < plen);
    assign cell_pat[k]  = pick_byte({pat_hi_q, pat_lo_q},
                                    IdxW4'(plen - LenW'(1) - LenW'(k)));
    if (k == 0) begin : g_head
      sfr_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (accept),
        .byte_i     (s_axis_tdata_i),
        .pat_byte_i (cell_pat[k]),
        .in_use_i   (cell_used[k]),
        .match_i    (1'b1),
        .byte_o     (cell_byte[k]),
        .match_o    (cell_match[k]),
        .snap_o     (cell_snap[k])
      );
    end else begin : g_body
      sfr_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (accept),
        .byte_i     (cell_byte[k-1]),
        .pat_byte_i (cell_pat[k]),
        .in_use_i   (cell_used[k]),
        .match_i    (cell_match[k-1]),
        .byte_o     (cell_byte[k]),
        .match_o    (cell_match[k]),
        .snap_o     (cell_snap[k])
      );
    end
  end

  assign hit = cell_match[MaxWordBytes-1];

  always_comb begin
    burst_load = '{kind: BURST_WIN, idx: '0, rem: '0, done: last};
    if (full && hit) begin
      if (rlen != '0) begin
        burst_load.kind = BURST_REPL;
        burst_load.rem  = rlen;
      end else if (last) begin
        burst_load.kind = BURST_MARK;
        burst_load.rem  = LenW'(1);
      end
    end else if (full) begin
      // The oldest byte goes out; at the end of the string the rest follows.
      burst_load.idx = IdxW4'(plen - LenW'(1));
      burst_load.rem = last ? plen : LenW'(1);
    end else if (last) begin
      burst_load.idx = IdxW4'(fill_new - LenW'(1));
      burst_load.rem = fill_new;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg_we_i && (cfg_addr_i == CfgPatLen)) begin
      fill_d = '0;
    end else if (accept) begin
      if (last || (full && hit)) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = FillW'(plen - LenW'(1));
      end else begin
        fill_d = FillW'(fill_new);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  sfr_out #(
    .MaxWordBytes (MaxWordBytes)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .burst_i    (burst_load),
    .snap_i     (cell_snap),
    .repl_i     ({rep_hi_q, rep_lo_q}),
    .ready_o    (s_axis_tready_o),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .out_byte_o (out_byte),
    .present_o  (m_axis_tuser_o[0]),
    .run_last_o (out_run_last),
    .done_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'b0, out_run_last, out_byte};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(fill_q) <= LenW'(MaxWordBytes))
    else $error("window fill beyond depth");

  a_end_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (fill_q == '0))
    else $error("window not emptied at end of string");

  a_marker_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tlast_o && m_axis_tdata_o[8]))
    else $error("end-only marker outside the end of a string");

  a_done_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tdata_o[8])
    else $error("string end not on the last result of a byte");

endmodule

>>> design/sfr_cell.sv
// One window cell: holds a text byte, compares it with its pattern byte, keeps a snapshot.
module sfr_cell
  import sfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             shift_en_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] pat_byte_i,
  input  logic             in_use_i,
  input  logic             match_i,
  output logic [ByteW-1:0] byte_o,
  output logic             match_o,
  output logic [ByteW-1:0] snap_o
);

  logic [ByteW-1:0] byte_q, byte_d;
  logic [ByteW-1:0] snap_q, snap_d;

  // The compare looks at the byte this cell holds after the transfer in progress.
  assign match_o = match_i & (!in_use_i || (byte_i == pat_byte_i));

  always_comb begin
    byte_d = byte_q;
    snap_d = snap_q;
    if (shift_en_i) begin
      byte_d = byte_i;
      snap_d = byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    snap_q <= snap_d;
  end

  assign byte_o = byte_q;
  assign snap_o = snap_q;

endmodule

>>> design/sfr_out.sv
// Result sequencer: steps through a burst of results and feeds the output register.
module sfr_out
  import sfr_pkg::*;
#(
  parameter int unsigned MaxWordBytes = MaxWordBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sfr_burst_t            burst_i,
  input  logic [ByteW-1:0]      snap_i [MaxWordBytes],
  input  logic [2*CfgDataW-1:0] repl_i,
  output logic                  ready_o,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  present_o,
  output logic                  run_last_o,
  output logic                  done_o
);

  localparam int unsigned IdxW = (MaxWordBytes > 1) ? $clog2(MaxWordBytes) : 1;

  sfr_burst_t       burst_q, burst_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_present_q, out_present_d;
  logic             out_run_last_q, out_run_last_d;
  logic             out_done_q, out_done_d;
  logic             advance;
  logic [ByteW-1:0] sel_byte;
  logic             sel_present;

  assign advance = (burst_q.rem != '0) && (!out_valid_q || m_tready_i);
  assign ready_o = (burst_q.rem == '0) || ((burst_q.rem == LenW'(1)) && advance);

  always_comb begin
    sel_byte    = '0;
    sel_present = 1'b0;
    case (burst_q.kind)
      BURST_REPL: begin
        sel_byte    = pick_byte(repl_i, burst_q.idx);
        sel_present = 1'b1;
      end
      BURST_WIN: begin
        sel_byte    = snap_i[burst_q.idx[IdxW-1:0]];
        sel_present = 1'b1;
      end
      BURST_MARK: begin
        sel_byte    = '0;
        sel_present = 1'b0;
      end
      default: begin
        sel_byte    = '0;
        sel_present = 1'b0;
      end
    endcase
  end

  // Window bytes were snapshotted newest first, so a window burst walks downward.
  always_comb begin
    burst_d = burst_q;
    if (advance) begin
      burst_d.rem = burst_q.rem - LenW'(1);
      if (burst_q.kind == BURST_WIN) begin
        burst_d.idx = burst_q.idx - IdxW4'(1);
      end else begin
        burst_d.idx = burst_q.idx + IdxW4'(1);
      end
    end
    if (load_i) begin
      burst_d = burst_i;
    end
  end

  always_comb begin
    out_valid_d    = out_valid_q;
    out_byte_d     = out_byte_q;
    out_present_d  = out_present_q;
    out_run_last_d = out_run_last_q;
    out_done_d     = out_done_q;
    if (advance) begin
      out_valid_d    = 1'b1;
      out_byte_d     = sel_byte;
      out_present_d  = sel_present;
      out_run_last_d = (burst_q.rem == LenW'(1));
      out_done_d     = (burst_q.rem == LenW'(1)) && burst_q.done;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q     <= '{kind: BURST_MARK, idx: '0, rem: '0, done: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      burst_q     <= burst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q     <= out_byte_d;
    out_present_q  <= out_present_d;
    out_run_last_q <= out_run_last_d;
    out_done_q     <= out_done_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign out_byte_o = out_byte_q;
  assign present_o  = out_present_q;
  assign run_last_o = out_run_last_q;
  assign done_o     = out_done_q;

endmodule

>>> tb/tb_stream_find_and_replace_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stream find-and-replace unit with its own byte-level predictor.
module tb_stream_find_and_replace_unit;
  import sfr_pkg::*;

  localparam int unsigned StallMax      = 11;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned ItemsTarget   = 310;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_present;
    logic             run_last;
    logic             string_done;
  } text_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;
  logic                s_axis_tlast_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [15:0]         m_axis_tdata_o;
  logic [0:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  stream_find_and_replace_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Shadow copy of the registers and the match window.
  logic [2*CfgDataW-1:0] pattern_bits;
  logic [2*CfgDataW-1:0] replacement_bits;
  logic [LenW-1:0]       pattern_len_reg;
  logic [LenW-1:0]       replacement_len_reg;
  logic [ByteW-1:0]      window_bytes [MaxWordBytesDef];
  int unsigned           window_count;

  text_out_t   awaited_bytes_q [$];
  text_out_t   front_result;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off_request = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_pattern_len();
    if (pattern_len_reg == 0) return 1;
    if (pattern_len_reg > MaxWordBytesDef) return MaxWordBytesDef;
    return pattern_len_reg;
  endfunction

  function automatic int unsigned active_replacement_len();
    return (replacement_len_reg > ReplMaxBytes) ? ReplMaxBytes : replacement_len_reg;
  endfunction

  function automatic text_out_t make_out(logic [ByteW-1:0] value, logic present);
    text_out_t r;
    r.out_byte     = value;
    r.byte_present = present;
    r.run_last     = 1'b0;
    r.string_done  = 1'b0;
    return r;
  endfunction

  // Computes the output bytes caused by one accepted text byte and queues them.
  function automatic void replace_step(logic [ByteW-1:0] text, logic eot);
    int unsigned plen;
    int unsigned last_idx;
    bit          hit;
    text_out_t   produced [$];
    plen = active_pattern_len();
    if (window_count >= plen) window_count = plen - 1;
    window_bytes[window_count] = text;
    window_count++;
    if (window_count == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (window_bytes[i] != pattern_bits[i*ByteW +: ByteW]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < active_replacement_len(); i++) begin
          produced.push_back(make_out(replacement_bits[i*ByteW +: ByteW], 1'b1));
        end
        window_count = 0;
      end else begin
        produced.push_back(make_out(window_bytes[0], 1'b1));
        for (int i = 1; i < window_count; i++) window_bytes[i-1] = window_bytes[i];
        window_count--;
      end
    end
    if (eot) begin
      for (int i = 0; i < window_count; i++) produced.push_back(make_out(window_bytes[i], 1'b1));
      window_count = 0;
      // A string that leaves nothing behind still ends with a bare end marker.
      if (produced.size() == 0) produced.push_back(make_out('0, 1'b0));
      last_idx = produced.size() - 1;
      produced[last_idx].string_done = 1'b1;
    end
    if (produced.size() != 0) begin
      last_idx = produced.size() - 1;
      produced[last_idx].run_last = 1'b1;
    end
    foreach (produced[i]) awaited_bytes_q.push_back(produced[i]);
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [CfgDataW-1:0] random_word64();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      CfgPatLo:  pattern_bits[CfgDataW-1:0] = value;
      CfgPatHi:  pattern_bits[2*CfgDataW-1:CfgDataW] = value;
      CfgPatLen: begin
        pattern_len_reg = value[LenW-1:0];
        window_count    = 0;
      end
      CfgRepLo:  replacement_bits[CfgDataW-1:0] = value;
      CfgRepHi:  replacement_bits[2*CfgDataW-1:CfgDataW] = value;
      CfgRepLen: replacement_len_reg = value[LenW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [2*CfgDataW-1:0] pattern, logic [LenW-1:0] pat_len,
                             logic [2*CfgDataW-1:0] replacement, logic [LenW-1:0] rep_len);
    write_reg(CfgPatLo, pattern[CfgDataW-1:0]);
    write_reg(CfgPatHi, pattern[2*CfgDataW-1:CfgDataW]);
    write_reg(CfgPatLen, pat_len);
    write_reg(CfgRepLo, replacement[CfgDataW-1:0]);
    write_reg(CfgRepHi, replacement[2*CfgDataW-1:CfgDataW]);
    write_reg(CfgRepLen, rep_len);
  endtask

  task automatic send_text_byte(logic [ByteW-1:0] text, logic eot);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, StallMax) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= text;
    s_axis_tlast_i  <= eot;
    do @(posedge clk_i); while (!s_axis_tready_o);
    replace_step(text, eot);
    items_sent++;
  endtask

  // Lets every awaited byte arrive, then gives the pipeline time to go quiet.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (awaited_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly whole or partial copies of the pattern between random bytes, so matches are common.
  task automatic send_random_string();
    logic [ByteW-1:0] text_q [$];
    int unsigned      target;
    int unsigned      plen;
    int unsigned      cut;
    int unsigned      r;
    bit               split;
    target = $urandom_range(1, 24);
    plen   = active_pattern_len();
    while (text_q.size() < target) begin
      r = $urandom_range(0, 9);
      if (r < 4) cut = plen;
      else if (r < 6) cut = $urandom_range(1, (plen > 1) ? plen - 1 : 1);
      else cut = 0;
      if (cut == 0) text_q.push_back(ByteW'($urandom));
      else for (int i = 0; i < cut; i++) text_q.push_back(pattern_bits[i*ByteW +: ByteW]);
    end
    split = ($urandom_range(0, 9) == 0) && (text_q.size() > 1);
    foreach (text_q[i]) begin
      if (split && i == text_q.size() / 2) begin
        // A pattern length write in the middle of a string drops the pending window.
        wait_drained();
        write_reg(CfgPatLen, $urandom_range(0, 31));
      end
      send_text_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic test_reset_defaults();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    // Out of reset the pattern is a single zero byte and the replacement is empty.
    send_text_byte(8'h41, 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b1);
    send_text_byte(8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_pattern_hits();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    load_config({112'h0, 8'h80, 8'h00}, 5'd2, {104'h0, 8'h7E, 8'h01, 8'hFF}, 5'd3);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h80, 1'b1);
    wait_drained();
    send_text_byte(8'h00, 1'b0);
    wait_drained();
    write_reg(CfgPatLen, 2);
    send_text_byte(8'h80, 1'b1);
    wait_drained();
  endtask

  task automatic test_length_limits();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b0;
    // Pattern length zero behaves as one, replacement length 31 as sixteen.
    load_config({120'h0, 8'hFF}, 5'd0,
                {64'h0123456789ABCDEF, 64'hFEDCBA9876543210}, 5'd31);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h7F, 1'b1);
    wait_drained();
    write_reg(CfgPatLen, 17);
    write_reg(CfgRepLen, 0);
    send_text_byte(8'h01, 1'b0);
    send_text_byte(8'h02, 1'b0);
    send_text_byte(8'h03, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    load_config({120'h0, 8'h55}, 5'd1, {random_word64(), random_word64()}, 5'd16);
    hold_off_request = HoldOffCycles;
    for (int i = 0; i < 12; i++) send_text_byte(8'h55, i == 11);
    wait_drained();
  endtask

  task automatic test_random_phases();
    int unsigned r;
    int unsigned strings;
    logic [LenW-1:0] pat_len;
    logic [LenW-1:0] rep_len;
    while (items_sent < ItemsTarget) begin
      r = $urandom_range(0, 9);
      if (r < 6) pat_len = LenW'($urandom_range(1, 4));
      else if (r == 6) pat_len = LenW'(16);
      else if (r == 7) pat_len = '0;
      else if (r == 8) pat_len = LenW'($urandom_range(17, 31));
      else pat_len = LenW'($urandom_range(5, 15));
      r = $urandom_range(0, 9);
      if (r < 5) rep_len = LenW'($urandom_range(0, 4));
      else if (r == 5) rep_len = LenW'(16);
      else if (r == 6) rep_len = LenW'($urandom_range(17, 31));
      else rep_len = LenW'($urandom_range(5, 15));
      load_config({random_word64(), random_word64()}, pat_len,
                  {random_word64(), random_word64()}, rep_len);
      r = $urandom_range(0, 3);
      tx_gaps_on   = r[0];
      rx_stalls_on = r[1];
      strings = $urandom_range(3, 6);
      repeat (strings) begin
        if (items_sent < ItemsTarget) send_random_string();
      end
      wait_drained();
    end
  endtask

  initial begin : receiver
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_request != 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
      end else begin
        stall = rx_stalls_on ? $urandom_range(0, StallMax) : 0;
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_bytes_q.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual tdata=%h tuser=%h tlast=%b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        error_count++;
      end else begin
        front_result = awaited_bytes_q.pop_front();
        check_field("out_byte", front_result.out_byte, m_axis_tdata_o[7:0]);
        check_field("run_last", front_result.run_last, m_axis_tdata_o[8]);
        check_field("tdata padding", '0, m_axis_tdata_o[15:9]);
        check_field("byte_present", front_result.byte_present, m_axis_tuser_o[0]);
        check_field("string_done", front_result.string_done, m_axis_tlast_o);
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("stream_find_and_replace_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_addr_i      <= '0;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    pattern_bits        = '0;
    replacement_bits    = '0;
    pattern_len_reg     = 5'd1;
    replacement_len_reg = '0;
    window_count        = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_pattern_hits();
    test_length_limits();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (error_count == 0) begin
      $display("stream_find_and_replace_unit test passed");
    end else begin
      $display("stream_find_and_replace_unit test failed");
    end
    $finish;
  end

endmodule
